// File: design/amte_pkg.sv
// shared constants and types of the affine matrix transform engine
package amte_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam int WORD_BITS_DEF = 32;
   localparam int IO_BITS       = 32;
   localparam int CMD_BITS      = 3;
   localparam int IDX_BITS      = 4;
   localparam int MAT_SIZE      = 16;

   typedef enum logic [CMD_BITS-1:0] {
      CMD_IDENTITY  = 3'd0,
      CMD_ZERO      = 3'd1,
      CMD_WRITE_CUR = 3'd2,
      CMD_WRITE_OP  = 3'd3,
      CMD_COMPOSE   = 3'd4,
      CMD_POINT     = 3'd5,
      CMD_READ_CUR  = 3'd6
   } cmd_type;

   typedef struct packed {
      logic load;
      logic trans_en;
      logic mul_en;
      logic hi_half;
   } mac_ctl_type;

endpackage

// File: design/amte_req_if.sv
// command word channel of the transform engine
interface amte_req_if;
   logic                                valid;
   logic                                ready;
   logic [amte_pkg::CMD_BITS-1:0]       command;
   logic [amte_pkg::IDX_BITS-1:0]       element_index;
   logic signed [amte_pkg::IO_BITS-1:0] element_value;
   logic signed [amte_pkg::IO_BITS-1:0] point_x;
   logic signed [amte_pkg::IO_BITS-1:0] point_y;
   logic signed [amte_pkg::IO_BITS-1:0] point_z;

   modport source (
      output valid, command, element_index, element_value, point_x, point_y, point_z,
      input  ready
   );
   modport sink (
      input  valid, command, element_index, element_value, point_x, point_y, point_z,
      output ready
   );
endinterface

// File: design/amte_rsp_if.sv
// result word channel of the transform engine
interface amte_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [amte_pkg::IO_BITS-1:0] out_x;
   logic signed [amte_pkg::IO_BITS-1:0] out_y;
   logic signed [amte_pkg::IO_BITS-1:0] out_z;
   logic signed [amte_pkg::IO_BITS-1:0] read_data;
   logic                                saturated;

   modport source (
      output valid, out_x, out_y, out_z, read_data, saturated,
      input  ready
   );
   modport sink (
      input  valid, out_x, out_y, out_z, read_data, saturated,
      output ready
   );
endinterface

// File: design/amte_mac.sv
// shared split multiplier with wide accumulator, rounding and word saturation
module amte_mac #(
   parameter int FRAC_BITS = amte_pkg::FRAC_BITS_DEF,
   parameter int WORD_BITS = amte_pkg::WORD_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  amte_pkg::mac_ctl_type       ctl,
   input  logic signed [WORD_BITS-1:0] a,
   input  logic signed [WORD_BITS-1:0] b,
   input  logic signed [WORD_BITS-1:0] trans,
   output logic signed [WORD_BITS-1:0] result,
   output logic                        sat
);

   localparam int H   = (WORD_BITS + 1) / 2;
   localparam int PW  = 2 * WORD_BITS;
   localparam int ACC = 2 * WORD_BITS + 3;
   localparam logic signed [ACC-1:0] HALF   = ACC'(1) <<< (FRAC_BITS - 1);
   localparam logic signed [ACC-1:0] WMAX_A = ACC'({1'b0, {(WORD_BITS-1){1'b1}}});
   localparam logic signed [ACC-1:0] WMIN_A = ~WMAX_A;

   logic signed [H:0]               b_part;
   logic signed [WORD_BITS+H:0]     prod_part;
   logic signed [PW-1:0]            prod_in, prod_ff;
   logic                            prod_vld_in, prod_vld_ff;
   logic signed [ACC-1:0]           acc_in, acc_ff;
   logic signed [ACC-1:0]           rnd;

   always_comb begin
      b_part      = ctl.hi_half ? (H+1)'($signed(b[WORD_BITS-1:H]))
                                : $signed({1'b0, b[H-1:0]});
      prod_part   = a * b_part;
      prod_in     = ctl.hi_half ? (PW'(prod_part) <<< H) : PW'(prod_part);
      prod_vld_in = ctl.mul_en;
      if (ctl.load) begin
         acc_in = ctl.trans_en ? (ACC'(trans) <<< FRAC_BITS) : '0;
      end else if (prod_vld_ff) begin
         acc_in = acc_ff + ACC'(prod_ff);
      end else begin
         acc_in = acc_ff;
      end
   end

   // round once, drop fraction, clamp to word
   always_comb begin
      rnd = (acc_ff + HALF) >>> FRAC_BITS;
      sat = (rnd > WMAX_A) || (rnd < WMIN_A);
      if (rnd > WMAX_A) begin
         result = WMAX_A[WORD_BITS-1:0];
      end else if (rnd < WMIN_A) begin
         result = WMIN_A[WORD_BITS-1:0];
      end else begin
         result = rnd[WORD_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff <= 1'b0;
      end else begin
         prod_vld_ff <= prod_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

endmodule

// File: design/affine_matrix_transform_engine_unit.sv
// affine matrix transform engine top level: matrices, sequencer and result register
// set, write and read go from IDLE to DONE; compose and point run INIT, MUL_LO/MUL_HI
// per term, DRAIN and FIN for each of 16 elements (4 terms) or 3 outputs (3 terms)
// each product term takes two passes through the one shared half-width multiplier
// one word at a time, waiting in DONE on a held result; ready again as the result registers
// synchronous reset: both matrices load identity, channels go idle
module affine_matrix_transform_engine_unit #(
   parameter int FRAC_BITS = amte_pkg::FRAC_BITS_DEF,
   parameter int WORD_BITS = amte_pkg::WORD_BITS_DEF
) (
   input logic         clock,
   input logic         reset,
   amte_req_if.sink    req_bus,
   amte_rsp_if.source  rsp_bus
);

   localparam int IO  = amte_pkg::IO_BITS;
   localparam int MAT = amte_pkg::MAT_SIZE;
   localparam int XW  = (WORD_BITS > IO) ? WORD_BITS : IO;
   localparam logic signed [XW-1:0] WMAX_X = XW'({1'b0, {(WORD_BITS-1){1'b1}}});
   localparam logic signed [XW-1:0] WMIN_X = ~WMAX_X;
   localparam logic signed [XW-1:0] OMAX_X = XW'({1'b0, {(IO-1){1'b1}}});
   localparam logic signed [XW-1:0] OMIN_X = ~OMAX_X;
   localparam logic ONE_SAT = (FRAC_BITS >= WORD_BITS - 1);
   localparam logic [WORD_BITS-1:0] DIAG =
      ONE_SAT ? {1'b0, {(WORD_BITS-1){1'b1}}} : (WORD_BITS'(1) << FRAC_BITS);
   localparam logic [WORD_BITS-1:0] ZW = '0;
   localparam logic signed [WORD_BITS-1:0] IDENT [MAT] = '{
      DIAG, ZW, ZW, ZW,
      ZW, DIAG, ZW, ZW,
      ZW, ZW, DIAG, ZW,
      ZW, ZW, ZW, DIAG
   };
   localparam logic [1:0] TRANS_ROW    = 2'd3;
   localparam logic [1:0] LAST_COMPOSE = 2'd3;
   localparam logic [1:0] LAST_POINT   = 2'd2;
   localparam logic [3:0] LAST_ELEM    = 4'hF;

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_INIT   = 7'b0000010,
      ST_MUL_LO = 7'b0000100,
      ST_MUL_HI = 7'b0001000,
      ST_DRAIN  = 7'b0010000,
      ST_FIN    = 7'b0100000,
      ST_DONE   = 7'b1000000
   } state_type;

   function automatic logic signed [WORD_BITS-1:0] clamp_in(input logic signed [IO-1:0] v);
      logic signed [XW-1:0] x;
      x = XW'(v);
      if (x > WMAX_X) begin
         clamp_in = WMAX_X[WORD_BITS-1:0];
      end else if (x < WMIN_X) begin
         clamp_in = WMIN_X[WORD_BITS-1:0];
      end else begin
         clamp_in = x[WORD_BITS-1:0];
      end
   endfunction

   function automatic logic in_clip(input logic signed [IO-1:0] v);
      logic signed [XW-1:0] x;
      x = XW'(v);
      in_clip = (x > WMAX_X) || (x < WMIN_X);
   endfunction

   function automatic logic signed [IO-1:0] clamp_out(input logic signed [WORD_BITS-1:0] v);
      logic signed [XW-1:0] x;
      x = XW'(v);
      if (x > OMAX_X) begin
         clamp_out = OMAX_X[IO-1:0];
      end else if (x < OMIN_X) begin
         clamp_out = OMIN_X[IO-1:0];
      end else begin
         clamp_out = x[IO-1:0];
      end
   endfunction

   function automatic logic out_clip(input logic signed [WORD_BITS-1:0] v);
      logic signed [XW-1:0] x;
      x = XW'(v);
      out_clip = (x > OMAX_X) || (x < OMIN_X);
   endfunction

   state_type state_in, state_ff;
   logic signed [WORD_BITS-1:0] cur_in [MAT];
   logic signed [WORD_BITS-1:0] cur_ff [MAT];
   logic signed [WORD_BITS-1:0] op_in [MAT];
   logic signed [WORD_BITS-1:0] op_ff [MAT];
   logic signed [WORD_BITS-1:0] next_in [MAT];
   logic signed [WORD_BITS-1:0] next_ff [MAT];
   logic signed [WORD_BITS-1:0] p_in [3];
   logic signed [WORD_BITS-1:0] p_ff [3];
   logic signed [WORD_BITS-1:0] res_in [3];
   logic signed [WORD_BITS-1:0] res_ff [3];
   logic signed [WORD_BITS-1:0] rd_in, rd_ff;
   logic                        sat_in, sat_ff;
   logic                        point_in, point_ff;
   logic [1:0]                  i_in, i_ff, j_in, j_ff, q_in, q_ff;
   logic                        rsp_valid_in, rsp_valid_ff;
   logic signed [IO-1:0]        rsp_x_in, rsp_x_ff, rsp_y_in, rsp_y_ff, rsp_z_in, rsp_z_ff;
   logic signed [IO-1:0]        rsp_rd_in, rsp_rd_ff;
   logic                        rsp_sat_in, rsp_sat_ff;

   logic [amte_pkg::IDX_BITS-1:0] cur_addr;
   logic signed [WORD_BITS-1:0]   cur_rd, op_rd;
   logic signed [WORD_BITS-1:0]   mac_a, mac_b, mac_res;
   logic                          mac_sat;
   logic [1:0]                    last_q;
   amte_pkg::mac_ctl_type         mac_ctl;

   always_comb begin
      if (state_ff == ST_IDLE) begin
         cur_addr = req_bus.element_index;
      end else if (state_ff == ST_INIT) begin
         cur_addr = {TRANS_ROW, i_ff};
      end else begin
         cur_addr = {q_ff, i_ff};
      end
      cur_rd = cur_ff[cur_addr];
      op_rd  = op_ff[{j_ff, q_ff}];
      mac_a  = point_ff ? p_ff[q_ff] : cur_rd;
      mac_b  = point_ff ? cur_rd : op_rd;
      last_q = point_ff ? LAST_POINT : LAST_COMPOSE;
   end

   amte_mac #(
      .FRAC_BITS (FRAC_BITS),
      .WORD_BITS (WORD_BITS)
   ) u_mac (
      .clock  (clock),
      .reset  (reset),
      .ctl    (mac_ctl),
      .a      (mac_a),
      .b      (mac_b),
      .trans  (cur_rd),
      .result (mac_res),
      .sat    (mac_sat)
   );

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      op_in        = op_ff;
      next_in      = next_ff;
      p_in         = p_ff;
      res_in       = res_ff;
      rd_in        = rd_ff;
      sat_in       = sat_ff;
      point_in     = point_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      q_in         = q_ff;
      mac_ctl      = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_z_in     = rsp_z_ff;
      rsp_rd_in    = rsp_rd_ff;
      rsp_sat_in   = rsp_sat_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_bus.valid) begin
               for (int k = 0; k < 3; k++) begin
                  res_in[k] = '0;
               end
               rd_in    = '0;
               sat_in   = 1'b0;
               i_in     = '0;
               j_in     = '0;
               q_in     = '0;
               state_in = ST_DONE;
               case (req_bus.command)
                  amte_pkg::CMD_IDENTITY: begin
                     cur_in = IDENT;
                     sat_in = ONE_SAT;
                  end
                  amte_pkg::CMD_ZERO: begin
                     for (int k = 0; k < MAT; k++) begin
                        cur_in[k] = '0;
                     end
                  end
                  amte_pkg::CMD_WRITE_CUR: begin
                     cur_in[req_bus.element_index] = clamp_in(req_bus.element_value);
                     sat_in = in_clip(req_bus.element_value);
                  end
                  amte_pkg::CMD_WRITE_OP: begin
                     op_in[req_bus.element_index] = clamp_in(req_bus.element_value);
                     sat_in = in_clip(req_bus.element_value);
                  end
                  amte_pkg::CMD_COMPOSE: begin
                     point_in = 1'b0;
                     state_in = ST_INIT;
                  end
                  amte_pkg::CMD_POINT: begin
                     point_in = 1'b1;
                     p_in[0]  = clamp_in(req_bus.point_x);
                     p_in[1]  = clamp_in(req_bus.point_y);
                     p_in[2]  = clamp_in(req_bus.point_z);
                     sat_in   = in_clip(req_bus.point_x) || in_clip(req_bus.point_y) ||
                                in_clip(req_bus.point_z);
                     state_in = ST_INIT;
                  end
                  amte_pkg::CMD_READ_CUR: begin
                     rd_in = cur_rd;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_INIT: begin
            mac_ctl.load     = 1'b1;
            mac_ctl.trans_en = point_ff;
            q_in             = '0;
            state_in         = ST_MUL_LO;
         end
         ST_MUL_LO: begin
            mac_ctl.mul_en = 1'b1;
            state_in       = ST_MUL_HI;
         end
         ST_MUL_HI: begin
            mac_ctl.mul_en  = 1'b1;
            mac_ctl.hi_half = 1'b1;
            if (q_ff == last_q) begin
               state_in = ST_DRAIN;
            end else begin
               q_in     = q_ff + 2'd1;
               state_in = ST_MUL_LO;
            end
         end
         ST_DRAIN: begin
            state_in = ST_FIN;
         end
         ST_FIN: begin
            sat_in = sat_ff || mac_sat;
            if (point_ff) begin
               res_in[i_ff] = mac_res;
               if (i_ff == LAST_POINT) begin
                  state_in = ST_DONE;
               end else begin
                  i_in     = i_ff + 2'd1;
                  state_in = ST_INIT;
               end
            end else begin
               next_in[{j_ff, i_ff}] = mac_res;
               if ({j_ff, i_ff} == LAST_ELEM) begin
                  cur_in   = next_in;
                  state_in = ST_DONE;
               end else begin
                  {j_in, i_in} = 4'({j_ff, i_ff} + 4'd1);
                  state_in     = ST_INIT;
               end
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in = 1'b1;
               rsp_x_in     = clamp_out(res_ff[0]);
               rsp_y_in     = clamp_out(res_ff[1]);
               rsp_z_in     = clamp_out(res_ff[2]);
               rsp_rd_in    = clamp_out(rd_ff);
               rsp_sat_in   = sat_ff || out_clip(res_ff[0]) || out_clip(res_ff[1]) ||
                              out_clip(res_ff[2]) || out_clip(rd_ff);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         cur_ff       <= IDENT;
         op_ff        <= IDENT;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cur_ff       <= cur_in;
         op_ff        <= op_in;
      end
   end

   always_ff @(posedge clock) begin
      next_ff    <= next_in;
      p_ff       <= p_in;
      res_ff     <= res_in;
      rd_ff      <= rd_in;
      sat_ff     <= sat_in;
      point_ff   <= point_in;
      i_ff       <= i_in;
      j_ff       <= j_in;
      q_ff       <= q_in;
      rsp_x_ff   <= rsp_x_in;
      rsp_y_ff   <= rsp_y_in;
      rsp_z_ff   <= rsp_z_in;
      rsp_rd_ff  <= rsp_rd_in;
      rsp_sat_ff <= rsp_sat_in;
   end

   assign req_bus.ready     = (state_ff == ST_IDLE);
   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.out_x     = rsp_x_ff;
   assign rsp_bus.out_y     = rsp_y_ff;
   assign rsp_bus.out_z     = rsp_z_ff;
   assign rsp_bus.read_data = rsp_rd_ff;
   assign rsp_bus.saturated = rsp_sat_ff;

endmodule
